@@ rtl/kpl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kpl_pkg
// Shared types and constants of the kerning pair lookup unit.
// ----------------------------------------------------------------------------
package kpl_pkg;

   localparam int GLYPH_W  = 16;
   localparam int ADJ_W    = 16;
   localparam int SLOT_W   = 12;
   localparam int BASE_W   = 12;
   localparam int LEN_W    = 13;
   localparam int COV_W    = 17;
   localparam int SPAN_W   = 14;
   localparam int RCNT_W   = 7;
   localparam int SCNT_W   = 11;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   typedef enum logic [1:0] {
      REQ_RANGE = 2'd0,
      REQ_SET   = 2'd1,
      REQ_PAIR  = 2'd2,
      REQ_QUERY = 2'd3
   } kpl_req_type;

   localparam logic CSR_RANGE_COUNT = 1'b0;
   localparam logic CSR_SET_COUNT   = 1'b1;

   typedef struct packed {
      logic             done;
      logic             hit;
      logic [COV_W-1:0] cov;
   } kpl_range_stat_type;

   typedef struct packed {
      logic                    done;
      logic                    found;
      logic signed [ADJ_W-1:0] kern;
   } kpl_pair_stat_type;

endpackage
`default_nettype wire

@@ rtl/kpl_range_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kpl_range_unit
// Coverage range table and its in-order scanner: one record compared per
// cycle against the left glyph, first containing record gives the index.
// ----------------------------------------------------------------------------
module kpl_range_unit import kpl_pkg::*; #(
   parameter int RANGES = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_en,
   input  wire logic [SLOT_W-1:0]   wr_slot,
   input  wire logic [GLYPH_W-1:0]  wr_first,
   input  wire logic [GLYPH_W-1:0]  wr_last,
   input  wire logic [GLYPH_W-1:0]  wr_cov,
   input  wire logic                go,
   input  wire logic [RCNT_W-1:0]   range_count,
   input  wire logic [GLYPH_W-1:0]  left,
   output kpl_range_stat_type       stat
);

   localparam int RA_W = (RANGES > 1) ? $clog2(RANGES) : 1;
   localparam int RC_W = $clog2(RANGES + 1);

   typedef enum logic [1:0] {
      R_IDLE = 2'b01,
      R_SCAN = 2'b10
   } rstate_type;

   logic [GLYPH_W-1:0] first_mem [RANGES];
   logic [GLYPH_W-1:0] last_mem  [RANGES];
   logic [GLYPH_W-1:0] cov_mem   [RANGES];

   logic [GLYPH_W-1:0] first_q, last_q, cov_q;

   rstate_type       state_ff, state_in;
   logic [RC_W-1:0]  idx_ff, idx_in;
   logic [RC_W-1:0]  limit_ff, limit_in;
   logic             pend_ff, pend_in;
   logic             rd_en, can_rd, hit, done;

   always_ff @(posedge clock) begin
      if (wr_en && (32'(wr_slot) < RANGES)) begin
         first_mem[RA_W'(wr_slot)] <= wr_first;
         last_mem[RA_W'(wr_slot)]  <= wr_last;
         cov_mem[RA_W'(wr_slot)]   <= wr_cov;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         first_q <= first_mem[idx_ff[RA_W-1:0]];
         last_q  <= last_mem[idx_ff[RA_W-1:0]];
         cov_q   <= cov_mem[idx_ff[RA_W-1:0]];
      end
   end

   assign can_rd = (idx_ff < limit_ff);
   assign hit    = pend_ff && (left >= first_q) && (left <= last_q);
   assign done   = (state_ff == R_SCAN) && (hit || (!pend_ff && !can_rd));

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      limit_in = limit_ff;
      pend_in  = 1'b0;
      rd_en    = 1'b0;
      case (state_ff)
         R_IDLE: begin
            if (go) begin
               idx_in   = '0;
               limit_in = (32'(range_count) > RANGES) ? RC_W'(RANGES) : RC_W'(range_count);
               state_in = R_SCAN;
            end
         end
         R_SCAN: begin
            if (done) begin
               state_in = R_IDLE;
            end else if (can_rd) begin
               rd_en   = 1'b1;
               idx_in  = idx_ff + 1'b1;
               pend_in = 1'b1;
            end
         end
         default: state_in = R_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      limit_ff <= limit_in;
   end

   assign stat.done = done;
   assign stat.hit  = hit;
   assign stat.cov  = COV_W'(cov_q) + COV_W'(left) - COV_W'(first_q);

endmodule
`default_nettype wire

@@ rtl/kpl_pair_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kpl_pair_unit
// Pair set headers and pair value store with the in-order pair scanner:
// reads the set header, then compares one pair record per cycle.
// ----------------------------------------------------------------------------
module kpl_pair_unit import kpl_pkg::*; #(
   parameter int PAIR_SETS   = 1024,
   parameter int PAIR_VALUES = 4096
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    set_wr_en,
   input  wire logic                    pair_wr_en,
   input  wire logic [SLOT_W-1:0]       wr_slot,
   input  wire logic [BASE_W-1:0]       wr_base,
   input  wire logic [LEN_W-1:0]        wr_len,
   input  wire logic [GLYPH_W-1:0]      wr_glyph,
   input  wire logic signed [ADJ_W-1:0] wr_adjust,
   input  wire logic                    go,
   input  wire logic [COV_W-1:0]        cov,
   input  wire logic [GLYPH_W-1:0]      right,
   output kpl_pair_stat_type            stat
);

   localparam int SA_W = (PAIR_SETS > 1) ? $clog2(PAIR_SETS) : 1;
   localparam int PA_W = (PAIR_VALUES > 1) ? $clog2(PAIR_VALUES) : 1;

   typedef enum logic [2:0] {
      P_IDLE = 3'b001,
      P_HDR  = 3'b010,
      P_SCAN = 3'b100
   } pstate_type;

   logic [BASE_W-1:0]       base_mem  [PAIR_SETS];
   logic [LEN_W-1:0]        len_mem   [PAIR_SETS];
   logic [GLYPH_W-1:0]      glyph_mem [PAIR_VALUES];
   logic signed [ADJ_W-1:0] adj_mem   [PAIR_VALUES];

   logic [BASE_W-1:0]       base_q;
   logic [LEN_W-1:0]        len_q;
   logic [GLYPH_W-1:0]      glyph_q;
   logic signed [ADJ_W-1:0] adj_q;

   pstate_type        state_ff, state_in;
   logic [SPAN_W-1:0] addr_ff, addr_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic              pend_ff, pend_in;
   logic              hdr_rd, pair_rd, can_rd, hit, done;

   always_ff @(posedge clock) begin
      if (set_wr_en && (32'(wr_slot) < PAIR_SETS)) begin
         base_mem[SA_W'(wr_slot)] <= wr_base;
         len_mem[SA_W'(wr_slot)]  <= wr_len;
      end
   end

   always_ff @(posedge clock) begin
      if (pair_wr_en && (32'(wr_slot) < PAIR_VALUES)) begin
         glyph_mem[PA_W'(wr_slot)] <= wr_glyph;
         adj_mem[PA_W'(wr_slot)]   <= wr_adjust;
      end
   end

   always_ff @(posedge clock) begin
      if (hdr_rd) begin
         base_q <= base_mem[SA_W'(cov)];
         len_q  <= len_mem[SA_W'(cov)];
      end
   end

   always_ff @(posedge clock) begin
      if (pair_rd) begin
         glyph_q <= glyph_mem[PA_W'(addr_ff)];
         adj_q   <= adj_mem[PA_W'(addr_ff)];
      end
   end

   assign can_rd = (left_ff != '0) && (32'(addr_ff) < PAIR_VALUES);
   assign hit    = pend_ff && (glyph_q == right);
   assign done   = (state_ff == P_SCAN) && (hit || (!pend_ff && !can_rd));

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      left_in  = left_ff;
      pend_in  = 1'b0;
      hdr_rd   = 1'b0;
      pair_rd  = 1'b0;
      case (state_ff)
         P_IDLE: begin
            if (go) begin
               hdr_rd   = 1'b1;
               state_in = P_HDR;
            end
         end
         P_HDR: begin
            addr_in  = SPAN_W'(base_q);
            left_in  = len_q;
            state_in = P_SCAN;
         end
         P_SCAN: begin
            if (done) begin
               state_in = P_IDLE;
            end else if (can_rd) begin
               pair_rd = 1'b1;
               addr_in = addr_ff + 1'b1;
               left_in = left_ff - 1'b1;
               pend_in = 1'b1;
            end
         end
         default: state_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      left_ff <= left_in;
   end

   assign stat.done  = done;
   assign stat.found = hit;
   assign stat.kern  = hit ? adj_q : '0;

endmodule
`default_nettype wire

@@ rtl/kern_pair_lookup_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kern_pair_lookup_unit
// Kerning pair lookup: range coverage, pair set headers and pair values.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low. Request types
// range, set and pair write one table entry in the accept cycle and give no
// result; busy stays low, so writes may follow back to back. A query raises
// busy, scans the range records in order (one per cycle) for the left glyph,
// reads the pair set header of the coverage index, then scans that pair set
// (one record per cycle) for the right glyph. The result beat appears on
// rsp_kern_value / rsp_found with rsp_strobe high for one cycle. It appears
// when a pair matches or the set is empty, when the set runs out, when
// the coverage index is out of bounds and when no range holds the left
// glyph, which includes the case in which no range record is scanned.
// busy drops in the cycle the result beat is shown, so the next request can be
// taken then. The receiver cannot stall the result beat. Reset clears the
// control state and both csr registers; the tables keep no reset value and
// must be written before use. Registers: range_count at 0x0, set_count at 0x4.
// ----------------------------------------------------------------------------
module kern_pair_lookup_unit import kpl_pkg::*; #(
   parameter int RANGES      = 64,
   parameter int PAIR_SETS   = 1024,
   parameter int PAIR_VALUES = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [1:0]               req_type,
   input  wire logic [SLOT_W-1:0]        req_slot,
   input  wire logic [GLYPH_W-1:0]       req_first_glyph,
   input  wire logic [GLYPH_W-1:0]       req_last_glyph,
   input  wire logic [GLYPH_W-1:0]       req_coverage_start,
   input  wire logic [BASE_W-1:0]        req_pair_base,
   input  wire logic [LEN_W-1:0]         req_pair_count,
   input  wire logic [GLYPH_W-1:0]       req_second_glyph,
   input  wire logic signed [ADJ_W-1:0]  req_adjust,
   output logic                          rsp_strobe,
   output logic signed [ADJ_W-1:0]       rsp_kern_value,
   output logic                          rsp_found,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_AW-1:0]        paddr,
   input  wire logic [CSR_DW-1:0]        pwdata,
   output logic [CSR_DW-1:0]             prdata,
   output logic                          pready
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_RANGE = 3'b010,
      S_PAIR  = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [RCNT_W-1:0]       range_count_ff;
   logic [SCNT_W-1:0]       set_count_ff;
   logic [GLYPH_W-1:0]      left_ff, left_in;
   logic [GLYPH_W-1:0]      right_ff, right_in;
   logic                    strobe_ff, strobe_in;
   logic signed [ADJ_W-1:0] kern_ff, kern_in;
   logic                    found_ff, found_in;

   logic               accept, csr_wr;
   logic               range_go, pair_go;
   kpl_range_stat_type rstat;
   kpl_pair_stat_type  pstat;

   // csr port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_count_ff <= '0;
         set_count_ff   <= '0;
      end else if (csr_wr) begin
         case (paddr[2])
            CSR_RANGE_COUNT: range_count_ff <= pwdata[RCNT_W-1:0];
            CSR_SET_COUNT:   set_count_ff   <= pwdata[SCNT_W-1:0];
            default:         ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_RANGE_COUNT: prdata = CSR_DW'(range_count_ff);
         CSR_SET_COUNT:   prdata = CSR_DW'(set_count_ff);
         default:         prdata = '0;
      endcase
   end

   // request side
   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   kpl_range_unit #(
      .RANGES (RANGES)
   ) u_range (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (accept && (req_type == REQ_RANGE)),
      .wr_slot     (req_slot),
      .wr_first    (req_first_glyph),
      .wr_last     (req_last_glyph),
      .wr_cov      (req_coverage_start),
      .go          (range_go),
      .range_count (range_count_ff),
      .left        (left_ff),
      .stat        (rstat)
   );

   kpl_pair_unit #(
      .PAIR_SETS   (PAIR_SETS),
      .PAIR_VALUES (PAIR_VALUES)
   ) u_pair (
      .clock      (clock),
      .reset      (reset),
      .set_wr_en  (accept && (req_type == REQ_SET)),
      .pair_wr_en (accept && (req_type == REQ_PAIR)),
      .wr_slot    (req_slot),
      .wr_base    (req_pair_base),
      .wr_len     (req_pair_count),
      .wr_glyph   (req_second_glyph),
      .wr_adjust  (req_adjust),
      .go         (pair_go),
      .cov        (rstat.cov),
      .right      (right_ff),
      .stat       (pstat)
   );

   // query sequencer
   always_comb begin
      state_in  = state_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      strobe_in = 1'b0;
      kern_in   = kern_ff;
      found_in  = found_ff;
      range_go  = 1'b0;
      pair_go   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_type == REQ_QUERY)) begin
               left_in  = req_first_glyph;
               right_in = req_second_glyph;
               range_go = 1'b1;
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            if (rstat.done) begin
               if (rstat.hit && (rstat.cov < COV_W'(set_count_ff)) &&
                   (32'(rstat.cov) < PAIR_SETS)) begin
                  pair_go  = 1'b1;
                  state_in = S_PAIR;
               end else begin
                  strobe_in = 1'b1;
                  kern_in   = '0;
                  found_in  = 1'b0;
                  state_in  = S_IDLE;
               end
            end
         end
         S_PAIR: begin
            if (pstat.done) begin
               strobe_in = 1'b1;
               kern_in   = pstat.kern;
               found_in  = pstat.found;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
      kern_ff  <= kern_in;
      found_ff <= found_in;
   end

   // result beat
   assign rsp_strobe     = strobe_ff;
   assign rsp_kern_value = kern_ff;
   assign rsp_found      = found_ff;

endmodule
`default_nettype wire
